@@ rtl/core/ynsa_pkg.sv @@
// ----------------------------------------------------------------------------
// ynsa_pkg
// Shared widths, register codes, stage types and divider step for the
// nearest-neighbor YUV scaler address generator.
// ----------------------------------------------------------------------------
package ynsa_pkg;

	localparam int X_W       = 13;
	localparam int DIM_W     = 14;
	localparam int STRIDE_W  = 15;
	localparam int ADDR_W    = 28;
	localparam int PROD_W    = X_W + DIM_W;
	localparam int Q_W       = X_W;
	localparam int DIV_STEPS = Q_W;
	localparam int PLANE_W   = STRIDE_W + DIM_W;

	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 88;
	localparam int M_TUSER_W = 1;

	localparam logic [DIM_W-1:0]    MAX_DIM          = DIM_W'(8192);
	localparam logic [DIM_W-1:0]    RST_SRC_WIDTH    = DIM_W'(640);
	localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT   = DIM_W'(480);
	localparam logic [STRIDE_W-1:0] RST_SRC_STRIDE   = STRIDE_W'(1280);
	localparam logic [DIM_W-1:0]    RST_DST_WIDTH    = DIM_W'(640);
	localparam logic [DIM_W-1:0]    RST_DST_HEIGHT   = DIM_W'(480);

	typedef enum logic [2:0] {
		REG_PIXEL_FORMAT = 3'd0,
		REG_SRC_WIDTH    = 3'd1,
		REG_SRC_HEIGHT   = 3'd2,
		REG_SRC_STRIDE   = 3'd3,
		REG_DST_WIDTH    = 3'd4,
		REG_DST_HEIGHT   = 3'd5
	} reg_idx_t;

	typedef enum logic {
		FMT_YUYV   = 1'b0,
		FMT_YUV420 = 1'b1
	} fmt_t;

	typedef struct packed {
		fmt_t                fmt;
		logic [DIM_W-1:0]    src_width;
		logic [DIM_W-1:0]    src_height;
		logic [STRIDE_W-1:0] src_stride;
		logic [DIM_W-1:0]    dst_width;
		logic [DIM_W-1:0]    dst_height;
	} cfg_t;

	typedef struct packed {
		logic              inv;
		logic [PROD_W-1:0] px;
		logic [PROD_W-1:0] py;
		logic [PROD_W-1:0] pc;
	} front_t;

	typedef struct packed {
		logic [DIM_W-1:0] rem;
		logic [X_W-1:0]   num;
		logic [Q_W-1:0]   quo;
	} lane_t;

	typedef struct packed {
		logic           inv;
		logic [Q_W-1:0] sx;
		logic [Q_W-1:0] sy;
		logic [Q_W-1:0] cy;
	} div_t;

	typedef struct packed {
		logic              inv;
		logic [Q_W-1:0]    sx;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] coff_m;
		logic [ADDR_W-1:0] plane;
		logic [ADDR_W-1:0] extra;
	} p1_t;

	typedef struct packed {
		logic              inv;
		logic [ADDR_W-1:0] luma;
		logic [ADDR_W-1:0] ycb;
		logic [ADDR_W-1:0] ycr;
		logic [ADDR_W-1:0] coff;
		logic [ADDR_W-1:0] cb_plane;
		logic [ADDR_W-1:0] cr_plane;
	} mid_t;

	typedef struct packed {
		logic              inv;
		logic [ADDR_W-1:0] luma;
		logic [ADDR_W-1:0] cb;
		logic [ADDR_W-1:0] cr;
	} res_t;

	function automatic lane_t lane_init(logic [PROD_W-1:0] n);
		lane_t l;
		l.rem = n[PROD_W-1:X_W];
		l.num = n[X_W-1:0];
		l.quo = '0;
		return l;
	endfunction

	// one restoring division step, one quotient bit
	function automatic lane_t div_step(lane_t l, logic [DIM_W-1:0] d);
		lane_t          r;
		logic [DIM_W:0] t;
		logic [DIM_W:0] diff;
		logic           ge;
		t      = {l.rem, l.num[X_W-1]};
		diff   = t - {1'b0, d};
		ge     = (t >= {1'b0, d});
		r.rem  = ge ? diff[DIM_W-1:0] : t[DIM_W-1:0];
		r.num  = {l.num[X_W-2:0], 1'b0};
		r.quo  = {l.quo[Q_W-2:0], ge};
		return r;
	endfunction

endpackage

@@ rtl/core/ynsa_front.sv @@
// ----------------------------------------------------------------------------
// ynsa_front
// Input stage: range checks and the three scale products.
// ----------------------------------------------------------------------------
module ynsa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [12:0]         out_x,
	input  logic [12:0]         out_y,
	input  ynsa_pkg::cfg_t      cfg,
	output logic                v_s1,
	output ynsa_pkg::front_t    d_s1
);
	import ynsa_pkg::*;

	logic inv;
	logic dims_bad;

	always_comb begin
		dims_bad = cfg.src_width[0] | cfg.src_height[0]
			| (cfg.src_width < DIM_W'(2)) | (cfg.src_width > MAX_DIM)
			| (cfg.src_height < DIM_W'(2)) | (cfg.src_height > MAX_DIM)
			| (cfg.dst_width == '0) | (cfg.dst_width > MAX_DIM)
			| (cfg.dst_height == '0) | (cfg.dst_height > MAX_DIM);
		inv = dims_bad
			| ({1'b0, out_x} >= cfg.dst_width)
			| ({1'b0, out_y} >= cfg.dst_height);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.inv <= inv;
			d_s1.px  <= PROD_W'(out_x) * PROD_W'(cfg.src_width);
			d_s1.py  <= PROD_W'(out_y) * PROD_W'(cfg.src_height);
			d_s1.pc  <= PROD_W'(out_y[X_W-1:1]) * PROD_W'(cfg.src_height);
		end
	end

endmodule

@@ rtl/core/ynsa_div.sv @@
// ----------------------------------------------------------------------------
// ynsa_div
// Pipelined restoring divider, one quotient bit per stage, three lanes:
// source column, source row and chroma row.
// ----------------------------------------------------------------------------
module ynsa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  ynsa_pkg::front_t    d_in,
	input  ynsa_pkg::cfg_t      cfg,
	output logic                v_out,
	output ynsa_pkg::div_t      d_out
);
	import ynsa_pkg::*;

	logic [DIV_STEPS-1:0] v_s;
	logic [DIV_STEPS-1:0] inv_s;
	lane_t                lx_s [DIV_STEPS];
	lane_t                ly_s [DIV_STEPS];
	lane_t                lc_s [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STEPS-2:0], v_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s   <= {inv_s[DIV_STEPS-2:0], d_in.inv};
			lx_s[0] <= div_step(lane_init(d_in.px), cfg.dst_width);
			ly_s[0] <= div_step(lane_init(d_in.py), cfg.dst_height);
			lc_s[0] <= div_step(lane_init(d_in.pc), cfg.dst_height);
			for (int i = 1; i < DIV_STEPS; i++) begin
				lx_s[i] <= div_step(lx_s[i-1], cfg.dst_width);
				ly_s[i] <= div_step(ly_s[i-1], cfg.dst_height);
				lc_s[i] <= div_step(lc_s[i-1], cfg.dst_height);
			end
		end
	end

	assign v_out     = v_s[DIV_STEPS-1];
	assign d_out.inv = inv_s[DIV_STEPS-1];
	assign d_out.sx  = lx_s[DIV_STEPS-1].quo;
	assign d_out.sy  = ly_s[DIV_STEPS-1].quo;
	assign d_out.cy  = lc_s[DIV_STEPS-1].quo;

endmodule

@@ rtl/core/ynsa_addr.sv @@
// ----------------------------------------------------------------------------
// ynsa_addr
// Address stages: line and plane products, then the per-format sums.
// ----------------------------------------------------------------------------
module ynsa_addr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  ynsa_pkg::div_t      d_in,
	input  ynsa_pkg::cfg_t      cfg,
	output logic                v_s2,
	output ynsa_pkg::mid_t      d_s2
);
	import ynsa_pkg::*;

	logic              v_s1;
	p1_t               p_s1;
	logic [DIM_W-1:0]  half_stride;
	logic [Q_W-1:0]    half_height;
	logic [Q_W-2:0]    sx_half;

	assign half_stride = cfg.src_stride[STRIDE_W-1:1];
	assign half_height = cfg.src_height[DIM_W-1:1];
	assign sx_half     = p_s1.sx[Q_W-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1.inv    <= d_in.inv;
			p_s1.sx     <= d_in.sx;
			p_s1.base   <= ADDR_W'(d_in.sy) * ADDR_W'(cfg.src_stride);
			p_s1.coff_m <= ADDR_W'(d_in.cy) * ADDR_W'(half_stride);
			p_s1.plane  <= ADDR_W'(PLANE_W'(cfg.src_stride) * PLANE_W'(cfg.src_height));
			p_s1.extra  <= ADDR_W'(half_stride) * ADDR_W'(half_height);

			d_s2.inv      <= p_s1.inv;
			d_s2.luma     <= (cfg.fmt == FMT_YUV420) ? p_s1.base + ADDR_W'(p_s1.sx)
				: p_s1.base + ADDR_W'({p_s1.sx, 1'b0});
			d_s2.ycb      <= p_s1.base + ADDR_W'({sx_half, 2'b01});
			d_s2.ycr      <= p_s1.base + ADDR_W'({sx_half, 2'b11});
			d_s2.coff     <= p_s1.coff_m + ADDR_W'(sx_half);
			d_s2.cb_plane <= p_s1.plane;
			d_s2.cr_plane <= p_s1.plane + p_s1.extra;
		end
	end

endmodule

@@ rtl/core/ynsa_out.sv @@
// ----------------------------------------------------------------------------
// ynsa_out
// Final chroma select, output register and skid register; drives the
// pipeline advance enable.
// ----------------------------------------------------------------------------
module ynsa_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                v_in,
	input  ynsa_pkg::mid_t      d_in,
	input  ynsa_pkg::fmt_t      fmt,
	output logic                en,
	output logic                out_valid,
	input  logic                out_ready,
	output ynsa_pkg::res_t      out_res
);
	import ynsa_pkg::*;

	res_t res;
	res_t out_q;
	res_t skid_q;
	logic out_v_q;
	logic skid_v_q;
	logic take;
	logic drain;

	always_comb begin
		res.inv  = d_in.inv;
		res.luma = d_in.luma;
		res.cb   = (fmt == FMT_YUV420) ? d_in.cb_plane + d_in.coff : d_in.ycb;
		res.cr   = (fmt == FMT_YUV420) ? d_in.cr_plane + d_in.coff : d_in.ycr;
		if (d_in.inv) begin
			res.luma = '0;
			res.cb   = '0;
			res.cr   = '0;
		end
	end

	assign en    = !skid_v_q;
	assign take  = v_in & en;
	assign drain = !out_v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			out_v_q  <= skid_v_q | take;
			skid_v_q <= 1'b0;
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

@@ rtl/core/yuv_nearest_scale_address_gen.sv @@
// ----------------------------------------------------------------------------
// yuv_nearest_scale_address_gen
// Source buffer addresses of the Y, Cb and Cr samples for nearest-neighbor
// scaling of packed YUYV or planar YUV420 frames.
//
// Input transfer: s_axis_tdata carries one output pixel coordinate.
// Output transfer: m_axis_tdata carries the three byte addresses,
// m_axis_tuser flags a request that cannot be served (addresses then zero).
// Registers sit on the APB port. The user must see that they are written
// only while no transfer is in flight; the block does not enforce this.
// From input transfer to m_axis_tvalid a request passes one product stage,
// 13 divider stages (one quotient bit each, set by the 13-bit coordinate
// range), two address stages and the output register. Throughput is one
// transfer per cycle while m_axis_tready stays high. Reset clears all valid
// bits and loads the register defaults; nothing needs clearing beyond that.
// When the receiver stalls, one more result lands in the skid register,
// then s_axis_tready falls and the whole pipeline holds its contents.
// ----------------------------------------------------------------------------
module yuv_nearest_scale_address_gen (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ynsa_pkg::PADDR_W-1:0]      paddr,
	input  logic [ynsa_pkg::PDATA_W-1:0]      pwdata,
	output logic [ynsa_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// out_x, out_y
	input  logic [ynsa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// luma_addr, cb_addr, cr_addr
	output logic [ynsa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// invalid
	output logic [ynsa_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
	import ynsa_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     en;
	logic     v_s1;
	front_t   d_s1;
	logic     v_div;
	div_t     d_div;
	logic     v_mid;
	mid_t     d_mid;
	res_t     res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt        <= FMT_YUYV;
			cfg_q.src_width  <= RST_SRC_WIDTH;
			cfg_q.src_height <= RST_SRC_HEIGHT;
			cfg_q.src_stride <= RST_SRC_STRIDE;
			cfg_q.dst_width  <= RST_DST_WIDTH;
			cfg_q.dst_height <= RST_DST_HEIGHT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PIXEL_FORMAT: cfg_q.fmt        <= fmt_t'(pwdata[0]);
				REG_SRC_WIDTH:    cfg_q.src_width  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT:   cfg_q.src_height <= pwdata[DIM_W-1:0];
				REG_SRC_STRIDE:   cfg_q.src_stride <= pwdata[STRIDE_W-1:0];
				REG_DST_WIDTH:    cfg_q.dst_width  <= pwdata[DIM_W-1:0];
				REG_DST_HEIGHT:   cfg_q.dst_height <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PIXEL_FORMAT: prdata = PDATA_W'(cfg_q.fmt);
			REG_SRC_WIDTH:    prdata = PDATA_W'(cfg_q.src_width);
			REG_SRC_HEIGHT:   prdata = PDATA_W'(cfg_q.src_height);
			REG_SRC_STRIDE:   prdata = PDATA_W'(cfg_q.src_stride);
			REG_DST_WIDTH:    prdata = PDATA_W'(cfg_q.dst_width);
			REG_DST_HEIGHT:   prdata = PDATA_W'(cfg_q.dst_height);
			default:          prdata = '0;
		endcase
	end

	assign s_axis_tready = en;

	ynsa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.out_x    (s_axis_tdata[X_W-1:0]),
		.out_y    (s_axis_tdata[2*X_W-1:X_W]),
		.cfg      (cfg_q),
		.v_s1     (v_s1),
		.d_s1     (d_s1)
	);

	ynsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_s1),
		.d_in   (d_s1),
		.cfg    (cfg_q),
		.v_out  (v_div),
		.d_out  (d_div)
	);

	ynsa_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.v_in   (v_div),
		.d_in   (d_div),
		.cfg    (cfg_q),
		.v_s2   (v_mid),
		.d_s2   (d_mid)
	);

	ynsa_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_mid),
		.d_in      (d_mid),
		.fmt       (cfg_q.fmt),
		.en        (en),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {(M_TDATA_W - 3*ADDR_W)'(0), res.cr, res.cb, res.luma};
	assign m_axis_tuser = res.inv;

endmodule

@@ rtl/core/ynsa_checker.sv @@
// ----------------------------------------------------------------------------
// ynsa_checker
// Port-level checks on the address generator, bound to the top level.
// ----------------------------------------------------------------------------
module ynsa_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [ynsa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input  logic [ynsa_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
	import ynsa_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output changed while stalled");

	// flagged results carry zero addresses
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero address");

	// skid can only be full behind a full output register
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// the first stall after an empty output never blocks the input
	a_one_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 (m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
		else $error("input blocked after a single stalled cycle");

endmodule

bind yuv_nearest_scale_address_gen ynsa_checker u_ynsa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
